FILE: hdl/dual_echo_ranger_assert.svh
// assertion macros for the ranger top level, sampled on clk and quiet during rst
`ifndef DUAL_ECHO_RANGER_ASSERT_SVH
`define DUAL_ECHO_RANGER_ASSERT_SVH

// consequent checked in the same cycle
`define DER_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dual_echo_ranger check failed");

// consequent checked in the next cycle
`define DER_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dual_echo_ranger check failed");

`endif

FILE: hdl/der_pkg.sv
package der_pkg;

  localparam int TIME_W    = 16;
  localparam int WIDTH_W   = 14;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LIMIT = 2'd1;

  localparam logic [TIME_W-1:0]  TIMEOUT_RESET     = 16'd500;
  localparam logic [WIDTH_W-1:0] WIDTH_LIMIT_RESET = 14'd10000;

  localparam logic ACT_POLL    = 1'b0;
  localparam logic ACT_CAPTURE = 1'b1;

  localparam logic SENSOR_RIGHT = 1'b0;
  localparam logic SENSOR_FRONT = 1'b1;

  // fresh_mask bit positions
  localparam int FRESH_FRONT = 0;
  localparam int FRESH_RIGHT = 1;

  typedef struct packed {
    logic              action;
    logic              sensor_id;
    logic [TIME_W-1:0] capture_value;
    logic [TIME_W-1:0] now_ms;
  } der_in_t;

  typedef struct packed {
    logic               trigger_fire;
    logic               trigger_sensor;
    logic               busy_res;
    logic               current_sensor;
    logic [WIDTH_W-1:0] front_width;
    logic [WIDTH_W-1:0] right_width;
    logic [1:0]         fresh_mask;
  } der_out_t;

  typedef struct packed {
    logic [TIME_W-1:0]  timeout_ms;
    logic [WIDTH_W-1:0] width_limit;
  } der_cfg_t;

endpackage

FILE: hdl/dual_echo_ranger.sv
// channel  | dir | payload    | handshake
// ---------+-----+------------+---------------------------------
// in       | in  | der_in_t   | in_valid / in_stall
// out      | out | der_out_t  | out_valid / out_stall
// cfg      | in  | 16-bit reg | cfg_we, cfg_index (no wait)
//
// one beat per clock sustained while out_stall is low; a taken beat is held in the input register,
// then in the result register behind one pass of compare/subtract logic
// rst is synchronous: timeout_ms 500, width_limit 10000, all sensor state cleared
// out_stall holds the result register; the input register still takes one more beat
// in_stall rises only when both registers are full and the result is stalled
`include "dual_echo_ranger_assert.svh"

module dual_echo_ranger (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  der_pkg::der_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output der_pkg::der_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [der_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [der_pkg::CFG_DATA_W-1:0]  cfg_data
);

  der_pkg::der_cfg_t  cfg;
  der_pkg::der_out_t  result;
  der_pkg::der_in_t   s1_data;
  logic               s1_valid;
  logic               s1_go;

  der_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  der_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_go),
    .item   (s1_data),
    .cfg    (cfg),
    .result (result)
  );

  // item in the input register moves on when the result register is free
  assign s1_go    = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data <= result;
    end
  end

  `DER_ASSERT_NOW(a_fire_busy, out_valid && out_data.trigger_fire,
    out_data.busy_res && (out_data.trigger_sensor == out_data.current_sensor))
  `DER_ASSERT_NOW(a_full_stalls, s1_valid && out_valid && out_stall, in_stall)
  `DER_ASSERT_NEXT(a_fresh_sticky, out_valid && !out_stall,
    !out_valid || ((out_data.fresh_mask & $past(out_data.fresh_mask))
                   == $past(out_data.fresh_mask)))

endmodule

FILE: hdl/der_cfg.sv
module der_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [der_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [der_pkg::CFG_DATA_W-1:0]  cfg_data,
  output der_pkg::der_cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ms  <= der_pkg::TIMEOUT_RESET;
      cfg.width_limit <= der_pkg::WIDTH_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        der_pkg::REG_TIMEOUT:     cfg.timeout_ms  <= cfg_data[der_pkg::TIME_W-1:0];
        der_pkg::REG_WIDTH_LIMIT: cfg.width_limit <= cfg_data[der_pkg::WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/der_core.sv
module der_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  der_pkg::der_in_t    item,
  input  der_pkg::der_cfg_t   cfg,
  output der_pkg::der_out_t   result
);

  logic                           owner_sensor, owner_sensor_next;
  logic                           in_progress, in_progress_next;
  logic [1:0]                     edge_seen, edge_seen_next;
  logic [der_pkg::TIME_W-1:0]     rise_stamp [2];
  logic [der_pkg::TIME_W-1:0]     rise_stamp_next [2];
  logic [der_pkg::TIME_W-1:0]     start_time, start_time_next;
  logic [der_pkg::WIDTH_W-1:0]    front_store, front_store_next;
  logic [der_pkg::WIDTH_W-1:0]    right_store, right_store_next;
  logic [1:0]                     fresh_bits, fresh_bits_next;
  logic                           fire;
  logic [der_pkg::TIME_W-1:0]     elapsed;
  logic [der_pkg::TIME_W-1:0]     echo_w;

  always_comb begin
    owner_sensor_next  = owner_sensor;
    in_progress_next   = in_progress;
    edge_seen_next     = edge_seen;
    rise_stamp_next[0] = rise_stamp[0];
    rise_stamp_next[1] = rise_stamp[1];
    start_time_next    = start_time;
    front_store_next   = front_store;
    right_store_next   = right_store;
    fresh_bits_next    = fresh_bits;
    fire               = 1'b0;
    elapsed            = item.now_ms - start_time;
    echo_w             = item.capture_value - rise_stamp[item.sensor_id];

    if (item.action == der_pkg::ACT_POLL) begin
      if (!in_progress) begin
        owner_sensor_next = ~owner_sensor;
        in_progress_next  = 1'b1;
        start_time_next   = item.now_ms;
        fire              = 1'b1;
        // a fresh ping has zero elapsed time, so it never times out here
        elapsed           = '0;
      end
      if (elapsed > cfg.timeout_ms) begin
        in_progress_next = 1'b0;
        edge_seen_next   = 2'b00;
      end
    end else if (item.sensor_id == owner_sensor) begin
      if (!edge_seen[item.sensor_id]) begin
        rise_stamp_next[item.sensor_id] = item.capture_value;
        edge_seen_next[item.sensor_id]  = 1'b1;
      end else begin
        if (echo_w < {2'b00, cfg.width_limit}) begin
          if (item.sensor_id == der_pkg::SENSOR_FRONT) begin
            front_store_next                     = echo_w[der_pkg::WIDTH_W-1:0];
            fresh_bits_next[der_pkg::FRESH_FRONT] = 1'b1;
          end else begin
            right_store_next                     = echo_w[der_pkg::WIDTH_W-1:0];
            fresh_bits_next[der_pkg::FRESH_RIGHT] = 1'b1;
          end
        end
        edge_seen_next[item.sensor_id] = 1'b0;
        in_progress_next               = 1'b0;
      end
    end

    result.trigger_fire   = fire;
    result.trigger_sensor = fire & owner_sensor_next;
    result.busy_res       = in_progress_next;
    result.current_sensor = owner_sensor_next;
    result.front_width    = front_store_next;
    result.right_width    = right_store_next;
    result.fresh_mask     = fresh_bits_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owner_sensor  <= 1'b0;
      in_progress   <= 1'b0;
      edge_seen     <= 2'b00;
      rise_stamp[0] <= '0;
      rise_stamp[1] <= '0;
      start_time    <= '0;
      front_store   <= '0;
      right_store   <= '0;
      fresh_bits    <= 2'b00;
    end else if (step) begin
      owner_sensor  <= owner_sensor_next;
      in_progress   <= in_progress_next;
      edge_seen     <= edge_seen_next;
      rise_stamp[0] <= rise_stamp_next[0];
      rise_stamp[1] <= rise_stamp_next[1];
      start_time    <= start_time_next;
      front_store   <= front_store_next;
      right_store   <= right_store_next;
      fresh_bits    <= fresh_bits_next;
    end
  end

endmodule
